// ===== src/pfrc_pkg.sv =====
// Shared codes, widths and the update result type for the page frame reference count table.
`default_nettype none
package pfrc_pkg;

  localparam int unsigned FRAME_W  = 52;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_MARK    = 3'd0;
  localparam logic [OP_W-1:0] OP_RETAIN  = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNREF   = 3'd4;

  // Outcome of one operation: the result beat and the write back to the table.
  typedef struct packed {
    logic                success;
    logic [COUNT_W-1:0]  count_now;
    logic                hand_back;
    logic [STATUS_W-1:0] status;
    logic                wr_en;
    logic [COUNT_W-1:0]  wr_count;
  } upd_t;

endpackage
`default_nettype wire

// ===== src/pfrc_update.sv =====
// Modify step of the read-modify-write: decides the new count and the result of one operation.
`default_nettype none
module pfrc_update (
  input  wire logic [pfrc_pkg::OP_W-1:0]    op,
  input  wire logic                         is_null,
  input  wire logic                         in_table,
  input  wire logic [pfrc_pkg::COUNT_W-1:0] cur,
  output pfrc_pkg::upd_t                    upd
);

  logic null_op;

  // Frame zero is null only for retain, release and query.
  assign null_op = is_null && (op == pfrc_pkg::OP_RETAIN || op == pfrc_pkg::OP_RELEASE ||
                               op == pfrc_pkg::OP_QUERY);

  always_comb begin
    upd = '0;
    upd.status = pfrc_pkg::ST_OK;
    if (op > pfrc_pkg::OP_CLEAR) begin
      upd = '0;
    end else if (null_op) begin
      upd.status = pfrc_pkg::ST_NULL;
    end else if (!in_table) begin
      upd.status    = pfrc_pkg::ST_OUTSIDE;
      upd.hand_back = (op == pfrc_pkg::OP_RELEASE);
    end else begin
      unique case (op)
        pfrc_pkg::OP_MARK: begin
          upd.success   = 1'b1;
          upd.count_now = pfrc_pkg::COUNT_W'(1);
          upd.wr_en     = 1'b1;
          upd.wr_count  = pfrc_pkg::COUNT_W'(1);
        end
        pfrc_pkg::OP_RETAIN: begin
          if (cur == '0 || cur == pfrc_pkg::COUNT_MAX) begin
            upd.status    = pfrc_pkg::ST_REFUSED;
            upd.count_now = cur;
          end else begin
            upd.success   = 1'b1;
            upd.count_now = cur + pfrc_pkg::COUNT_W'(1);
            upd.wr_en     = 1'b1;
            upd.wr_count  = cur + pfrc_pkg::COUNT_W'(1);
          end
        end
        pfrc_pkg::OP_RELEASE: begin
          if (cur == '0) begin
            upd.status = pfrc_pkg::ST_UNREF;
          end else begin
            upd.success   = 1'b1;
            upd.count_now = cur - pfrc_pkg::COUNT_W'(1);
            upd.hand_back = (cur == pfrc_pkg::COUNT_W'(1));
            upd.wr_en     = 1'b1;
            upd.wr_count  = cur - pfrc_pkg::COUNT_W'(1);
          end
        end
        pfrc_pkg::OP_QUERY: begin
          upd.success   = 1'b1;
          upd.count_now = cur;
        end
        default: begin
          // Clear.
          upd.success  = 1'b1;
          upd.wr_en    = 1'b1;
          upd.wr_count = '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/page_frame_refcount_table.sv =====
// Top level of the page frame reference count table: table memory, sequencer and stream ports.
//
//  Channel   Direction  Beat contents (lowest bits first)
//  s_*       in         op[2:0], frame_number[54:3], zero pad to 56 bits
//  m_*       out        success[0], count_now[16:1], hand_back[17], status[20:18], pad to 24
//  cfg_*     in         base_frame, written on any cycle with cfg_we high
//
// Each operation passes through the accept state, a look state that forms the table index
// and reads the count memory, and a modify state that modifies and writes the count back
// while loading the result register. With the single read port of the count memory and the
// one-operation-at-a-time sequencer, a new operation is taken only after the last is done.
// After reset the table is cleared one entry per cycle while s_tready stays low; cfg writes
// are taken during that pass.
// A stalled result register holds the next operation in its modify cycle, so one more
// operation can be accepted and read while the previous result waits on m_tready.
`default_nettype none
module page_frame_refcount_table #(
  parameter int unsigned TABLE_FRAMES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // op[2:0], frame_number[54:3], zero[55]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // success[0], count_now[16:1], hand_back[17],
                                      // status[20:18], zero[23:21]
  input  wire logic        cfg_we,
  input  wire logic [51:0] cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(TABLE_FRAMES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_FRAMES - 1);
  localparam logic [pfrc_pkg::INDEX_W-1:0] TABLE_SIZE = pfrc_pkg::INDEX_W'(TABLE_FRAMES);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOK   = 4'b0100,
    ST_MODIFY = 4'b1000
  } state_t;

  state_t state, state_next;

  // Configuration register.
  logic [pfrc_pkg::FRAME_W-1:0] base_frame;

  // Operation being worked on.
  logic [pfrc_pkg::OP_W-1:0]    op_q;
  logic [pfrc_pkg::FRAME_W-1:0] frame_q;
  logic [ADDR_W-1:0]            addr_q;
  logic                         inside_q;
  logic                         null_q;

  // Clearing pass address.
  logic [ADDR_W-1:0] clr_addr;

  // Count memory and its registered read data.
  logic [pfrc_pkg::COUNT_W-1:0] counts [TABLE_FRAMES];
  logic [pfrc_pkg::COUNT_W-1:0] rdata;

  logic [pfrc_pkg::FRAME_W-1:0] diff;
  logic [pfrc_pkg::INDEX_W-1:0] index;
  logic                         in_table;
  logic                         fire;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [pfrc_pkg::COUNT_W-1:0] mem_wdata;

  // Result register.
  logic                          out_success;
  logic [pfrc_pkg::COUNT_W-1:0]  out_count;
  logic                          out_hand_back;
  logic [pfrc_pkg::STATUS_W-1:0] out_status;

  pfrc_pkg::upd_t upd;

  // The table index is the frame offset from base_frame, taken modulo 2^32.
  assign diff     = frame_q - base_frame;
  assign index    = diff[pfrc_pkg::INDEX_W-1:0];
  assign in_table = (index < TABLE_SIZE);

  assign s_tready = (state == ST_IDLE);
  // The result register is free when empty or being drained in this cycle.
  assign fire     = (state == ST_MODIFY) && (!m_tvalid || m_tready);

  pfrc_update u_update (
    .op       (op_q),
    .is_null  (null_q),
    .in_table (inside_q),
    .cur      (rdata),
    .upd      (upd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE:   if (s_tvalid) state_next = ST_LOOK;
      ST_LOOK:   state_next = ST_MODIFY;
      ST_MODIFY: if (fire) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame <= '0;
    end else if (cfg_we) begin
      base_frame <= cfg_wdata;
    end
  end

  // Capture the operation on accept, then the index and flags in the read cycle.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q    <= s_tdata[2:0];
      frame_q <= s_tdata[54:3];
    end
    if (state == ST_LOOK) begin
      addr_q   <= index[ADDR_W-1:0];
      inside_q <= in_table;
      null_q   <= (frame_q == '0);
    end
  end

  // Single write port, shared by the clearing pass and the write back.
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = fire && upd.wr_en;
      mem_waddr = addr_q;
      mem_wdata = upd.wr_count;
    end
  end

  // Only one operation is in flight, so a read never overlaps a write to the same entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      counts[mem_waddr] <= mem_wdata;
    end
    if (state == ST_LOOK) begin
      rdata <= counts[index[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_success   <= upd.success;
      out_count     <= upd.count_now;
      out_hand_back <= upd.hand_back;
      out_status    <= upd.status;
    end
  end

  assign m_tdata = {3'b000, out_status, out_hand_back, out_count, out_success};

  // No operation is taken while the table is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready)
    else $error("operation accepted during clearing pass");

  // A new result only appears after a modify cycle.
  a_result_from_modify: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_MODIFY))
    else $error("result appeared without a modify cycle");

  // Write back only touches entries inside the table.
  a_write_inside: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MODIFY && upd.wr_en) |-> inside_q)
    else $error("write back to a frame outside the table");

  // A taken effect always reports status ok.
  a_success_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MODIFY && upd.success) |-> (upd.status == pfrc_pkg::ST_OK))
    else $error("success reported with an error status");

endmodule
`default_nettype wire

// ===== verif/tb_page_frame_refcount_table.sv =====
// Self-checking testbench for the page frame reference count table: random and directed traffic.
`default_nettype none
module tb_page_frame_refcount_table;

  localparam int unsigned TABLE_FRAMES = 65536;
  localparam int unsigned ADDR_W       = $clog2(TABLE_FRAMES);
  // Timeout, generous against the clearing pass and the random phases.
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned PHASE_ITEMS  = 390;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 16;

  localparam logic [pfrc_pkg::FRAME_W-1:0] FRAME_TOP = '1;
  // Op codes 5 to 7 are not assigned; the block must answer them with all-zero beats.
  localparam logic [pfrc_pkg::OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [pfrc_pkg::OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  typedef enum int unsigned {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_style_t;

  typedef struct packed {
    logic [pfrc_pkg::OP_W-1:0]    op;
    logic [pfrc_pkg::FRAME_W-1:0] frame;
    logic [3:0]                   gap;
  } frame_op_t;

  typedef struct packed {
    logic                          success;
    logic [pfrc_pkg::COUNT_W-1:0]  count_now;
    logic                          hand_back;
    logic [pfrc_pkg::STATUS_W-1:0] status;
  } count_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [55:0]                  s_tdata = '0;   // op[2:0], frame_number[54:3], zero[55]
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [23:0]                  m_tdata;        // success[0], count_now[16:1], hand_back[17],
                                                // status[20:18], zero[23:21]
  logic                         cfg_we = 1'b0;
  logic [pfrc_pkg::FRAME_W-1:0] cfg_wdata = '0;

  page_frame_refcount_table #(.TABLE_FRAMES(TABLE_FRAMES)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Shadow copy of the block: the window base and every reference count.
  logic [pfrc_pkg::FRAME_W-1:0] window_base = '0;
  logic [pfrc_pkg::COUNT_W-1:0] count_tbl [0:TABLE_FRAMES-1];

  frame_op_t     op_queue[$];          // operations waiting to be offered
  count_result_t expected_results[$];  // one entry per accepted beat, oldest first
  frame_op_t     on_bus;
  int unsigned   tx_wait = 0;
  int unsigned   rx_wait = 0;
  int unsigned   beats_in = 0;
  int unsigned   results_seen = 0;
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  int unsigned   hold_left = 0;
  bit            hold_arm = 1'b0;
  bit            hold_done = 1'b0;
  idle_style_t   tx_style = IDLE_FULL;
  idle_style_t   rx_style = IDLE_FULL;
  int unsigned   hot_slots[8];

  initial begin
    for (int i = 0; i < TABLE_FRAMES; i++) count_tbl[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  function automatic int unsigned draw_idle(input idle_style_t style);
    case (style)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 14);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
    endcase
  endfunction

  // Applies one operation to the shadow table and returns the beat it must produce.
  // The entry number is the low 32 bits of the distance from the window base, so a
  // frame 2^32 away from an in-window frame lands on the same entry.
  function automatic count_result_t apply_frame_op(input logic [pfrc_pkg::OP_W-1:0] op,
                                                   input logic [pfrc_pkg::FRAME_W-1:0] frame);
    count_result_t                r;
    logic [pfrc_pkg::FRAME_W-1:0] offset;
    logic [pfrc_pkg::INDEX_W-1:0] slot;
    logic [ADDR_W-1:0]            addr;
    logic [pfrc_pkg::COUNT_W-1:0] cur;
    r      = '0;
    offset = frame - window_base;
    slot   = offset[pfrc_pkg::INDEX_W-1:0];
    addr   = slot[ADDR_W-1:0];
    if (op > pfrc_pkg::OP_CLEAR) return r;
    if (frame == '0 && (op == pfrc_pkg::OP_RETAIN || op == pfrc_pkg::OP_RELEASE ||
                        op == pfrc_pkg::OP_QUERY)) begin
      r.status = pfrc_pkg::ST_NULL;
      return r;
    end
    if (slot >= TABLE_FRAMES) begin
      r.status    = pfrc_pkg::ST_OUTSIDE;
      r.hand_back = (op == pfrc_pkg::OP_RELEASE);
      return r;
    end
    cur = count_tbl[addr];
    case (op)
      pfrc_pkg::OP_MARK: begin
        count_tbl[addr] = pfrc_pkg::COUNT_W'(1);
        r.success   = 1'b1;
        r.count_now = pfrc_pkg::COUNT_W'(1);
      end
      pfrc_pkg::OP_RETAIN: begin
        if (cur == '0 || cur == pfrc_pkg::COUNT_MAX) begin
          r.count_now = cur;
          r.status    = pfrc_pkg::ST_REFUSED;
        end else begin
          count_tbl[addr] = cur + 1'b1;
          r.success   = 1'b1;
          r.count_now = cur + 1'b1;
        end
      end
      pfrc_pkg::OP_RELEASE: begin
        if (cur == '0) begin
          r.status = pfrc_pkg::ST_UNREF;
        end else begin
          // Dropping the last reference sends the frame back to the allocator.
          count_tbl[addr] = cur - 1'b1;
          r.success   = 1'b1;
          r.count_now = cur - 1'b1;
          r.hand_back = (cur == pfrc_pkg::COUNT_W'(1));
        end
      end
      pfrc_pkg::OP_QUERY: begin
        r.success   = 1'b1;
        r.count_now = cur;
      end
      default: begin
        count_tbl[addr] = '0;
        r.success = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Sender: offers queued operations, each after its own idle gap, and records the
  // expected beat at the edge where the block takes the item.
  always @(posedge clk) begin
    frame_op_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      tx_wait  <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_frame_op(on_bus.op, on_bus.frame));
        beats_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (op_queue.size() != 0 && tx_wait >= op_queue[0].gap) begin
          nxt = op_queue.pop_front();
          on_bus = nxt;
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, nxt.frame, nxt.op};
          tx_wait  <= 0;
        end else begin
          s_tvalid <= 1'b0;
          if (op_queue.size() != 0) tx_wait <= tx_wait + 1;
        end
      end
    end
  end

  // Receiver: takes result beats with random stalls and checks each field against
  // the oldest expectation. The stall style changes every few dozen beats.
  always @(posedge clk) begin
    count_result_t want;
    int unsigned   stall;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else begin
      stall = rx_wait;
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (results_seen % 48 == 0) rx_style = idle_style_t'($urandom_range(0, 2));
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[0] !== want.success)
            report_mismatch($sformatf("success expected %0d got %0d", want.success,
                                      m_tdata[0]));
          if (m_tdata[16:1] !== want.count_now)
            report_mismatch($sformatf("count_now expected %0d got %0d", want.count_now,
                                      m_tdata[16:1]));
          if (m_tdata[17] !== want.hand_back)
            report_mismatch($sformatf("hand_back expected %0d got %0d", want.hand_back,
                                      m_tdata[17]));
          if (m_tdata[20:18] !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d", want.status,
                                      m_tdata[20:18]));
        end
        stall = draw_idle(rx_style);
      end else if (stall != 0) begin
        stall--;
      end
      rx_wait  <= stall;
      m_tready <= (stall == 0) && (hold_left == 0);
    end
  end

  // Long receiver hold-off, started once on request, so the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_op(input logic [pfrc_pkg::OP_W-1:0] op,
                          input logic [pfrc_pkg::FRAME_W-1:0] frame);
    frame_op_t item;
    item.op    = op;
    item.frame = frame;
    item.gap   = 4'(draw_idle(tx_style));
    op_queue.push_back(item);
  endtask

  // Returns once nothing is queued, nothing is on the bus and no result is outstanding.
  task automatic wait_idle();
    @(negedge clk);
    while (op_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // The window base is only moved while the block is idle; the shadow follows it at
  // the edge where the block takes the write.
  task automatic set_window_base(input logic [pfrc_pkg::FRAME_W-1:0] base);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_we    <= 1'b0;
    window_base = base;
  endtask

  function automatic logic [pfrc_pkg::FRAME_W-1:0] rand_frame();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[pfrc_pkg::FRAME_W-1:0];
  endfunction

  // An in-window frame, now and then written with a multiple of 2^32 added.
  function automatic logic [pfrc_pkg::FRAME_W-1:0] window_frame(input int unsigned slot);
    logic [pfrc_pkg::FRAME_W-1:0] f;
    f = window_base + pfrc_pkg::FRAME_W'(slot);
    if ($urandom_range(0, 5) == 0) f = f + {20'($urandom()), 32'h0};
    return f;
  endfunction

  function automatic logic [pfrc_pkg::FRAME_W-1:0] noise_frame();
    case ($urandom_range(0, 5))
      0:       return rand_frame();
      1:       return '0;
      2:       return window_base - 1'b1;
      3:       return window_base + pfrc_pkg::FRAME_W'(TABLE_FRAMES);
      4:       return window_base + pfrc_pkg::FRAME_W'($urandom_range(0, TABLE_FRAMES - 1));
      default: return window_frame($urandom_range(0, TABLE_FRAMES - 1));
    endcase
  endfunction

  // One random phase. Most traffic works a small pool of entries, including both ends
  // of the window, so counts climb, fall back to zero and get refused; the rest is
  // noise with any op code and any frame.
  task automatic run_mixed_phase(input logic [pfrc_pkg::FRAME_W-1:0] base,
                                 input bit with_hold);
    int unsigned               pick;
    int unsigned               start;
    logic [pfrc_pkg::OP_W-1:0] op;
    set_window_base(base);
    hot_slots[0] = 0;
    hot_slots[1] = TABLE_FRAMES - 1;
    for (int i = 2; i < 8; i++) hot_slots[i] = $urandom_range(0, TABLE_FRAMES - 1);
    start = beats_in;
    for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
      if (i % 64 == 0) tx_style = idle_style_t'($urandom_range(0, 2));
      if ($urandom_range(0, 4) != 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 12)      op = pfrc_pkg::OP_MARK;
        else if (pick < 42) op = pfrc_pkg::OP_RETAIN;
        else if (pick < 74) op = pfrc_pkg::OP_RELEASE;
        else if (pick < 88) op = pfrc_pkg::OP_QUERY;
        else                op = pfrc_pkg::OP_CLEAR;
        queue_op(op, window_frame(hot_slots[$urandom_range(0, 7)]));
      end else begin
        queue_op(pfrc_pkg::OP_W'($urandom_range(0, 7)), noise_frame());
      end
    end
    if (with_hold) begin
      // Let traffic get going, then stall the result side while the sender keeps offering.
      @(negedge clk);
      while (beats_in < start + PHASE_ITEMS / 4) @(negedge clk);
      hold_arm = 1'b1;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the window at frame zero; the table starts all zero.
    set_window_base('0);
    queue_op(pfrc_pkg::OP_QUERY, '0);    // frame zero is null for query, retain and release
    queue_op(pfrc_pkg::OP_RETAIN, '0);
    queue_op(pfrc_pkg::OP_RELEASE, '0);
    queue_op(pfrc_pkg::OP_MARK, '0);     // but not for mark and clear
    queue_op(pfrc_pkg::OP_CLEAR, '0);
    queue_op(pfrc_pkg::OP_QUERY, pfrc_pkg::FRAME_W'(5));
    queue_op(pfrc_pkg::OP_RETAIN, pfrc_pkg::FRAME_W'(5));   // retain of an unreferenced frame
    queue_op(pfrc_pkg::OP_RELEASE, pfrc_pkg::FRAME_W'(5));  // release of an unreferenced frame
    queue_op(pfrc_pkg::OP_MARK, pfrc_pkg::FRAME_W'(5));
    queue_op(pfrc_pkg::OP_RETAIN, pfrc_pkg::FRAME_W'(5));
    queue_op(pfrc_pkg::OP_RELEASE, pfrc_pkg::FRAME_W'(5));
    queue_op(pfrc_pkg::OP_RELEASE, pfrc_pkg::FRAME_W'(5));  // last reference goes: hand back
    queue_op(pfrc_pkg::OP_RELEASE, pfrc_pkg::FRAME_W'(5));
    queue_op(pfrc_pkg::OP_MARK, pfrc_pkg::FRAME_W'(TABLE_FRAMES - 1));
    queue_op(pfrc_pkg::OP_QUERY, pfrc_pkg::FRAME_W'(TABLE_FRAMES - 1));
    // The first frame past the window; an outside release still hands back.
    queue_op(pfrc_pkg::OP_MARK, pfrc_pkg::FRAME_W'(TABLE_FRAMES));
    queue_op(pfrc_pkg::OP_RELEASE, pfrc_pkg::FRAME_W'(TABLE_FRAMES));
    queue_op(pfrc_pkg::OP_RETAIN, FRAME_TOP);
    queue_op(pfrc_pkg::OP_QUERY, FRAME_TOP);
    queue_op(pfrc_pkg::OP_CLEAR, FRAME_TOP);
    queue_op(pfrc_pkg::OP_MARK, {20'd1, 32'd7});             // 2^32 away from entry seven
    queue_op(pfrc_pkg::OP_QUERY, pfrc_pkg::FRAME_W'(7));
    queue_op(pfrc_pkg::OP_CLEAR, {20'hFFFFF, 32'd7});
    for (int unsigned u = OP_RSVD_FIRST; u <= OP_RSVD_LAST; u++)
      queue_op(pfrc_pkg::OP_W'(u), FRAME_TOP);
    queue_op(OP_RSVD_LAST, '0);
    wait_idle();

    // Random phases over several window positions, the extremes among them. The
    // top base wraps the window through frame zero.
    run_mixed_phase(FRAME_TOP, 1'b0);
    run_mixed_phase(rand_frame(), 1'b1);
    run_mixed_phase(52'h0_00FF_FFFF_C000, 1'b0);
    run_mixed_phase(rand_frame(), 1'b0);
    run_mixed_phase('0, 1'b0);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
